FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every enabled clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// types and constants shared by the seed text to long blocks
// ----------------------------------------------------------------------------
package stt_pkg;

    // request: one code unit of the seed text
    typedef struct packed {
        logic [15:0]        code_unit;
        logic               is_last;
        logic               no_text;
        logic signed [63:0] fallback_seed;
    } in_t;

    // result: one seed
    typedef struct packed {
        logic signed [63:0] seed;
        logic [1:0]         source;
    } out_t;

    // classified unit as it sits in the queue
    typedef struct packed {
        logic [15:0]        code_unit;
        logic               is_digit;
        logic [3:0]         digit;
        logic               is_plus;
        logic               is_minus;
        logic               is_last;
        logic               no_text;
        logic signed [63:0] fallback_seed;
    } unit_t;

    typedef enum logic [1:0] {
        SRC_PARSED   = 2'd0,
        SRC_HASH     = 2'd1,
        SRC_FALLBACK = 2'd2
    } source_t;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] CHAR_ZERO  = 16'h0030;
    localparam logic [15:0] CHAR_NINE  = 16'h0039;
    localparam logic [15:0] CHAR_MINUS = 16'h002D;
    localparam logic [15:0] CHAR_PLUS  = 16'h002B;

    localparam logic [31:0] HASH_MULT = 32'd31;

    // largest magnitude that can still take one more digit
    localparam logic [63:0] MAG_STEP_LIMIT = 64'd922337203685477580;
    // last digit allowed at that magnitude
    localparam logic [3:0]  LAST_DIGIT_POS = 4'd7;
    localparam logic [3:0]  LAST_DIGIT_NEG = 4'd8;

endpackage

FILE: sv/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// takes requests while the queue has room and classifies each code unit
// ----------------------------------------------------------------------------
module stt_front (
    input  logic          unit_valid,
    output logic          unit_stall,
    input  stt_pkg::in_t  unit_data,
    input  logic          q_full,
    output logic          push,
    output stt_pkg::unit_t push_data
);
    import stt_pkg::*;

    logic [15:0] c;
    logic [15:0] c_off;

    assign c          = unit_data.code_unit;
    assign c_off      = c - CHAR_ZERO;
    assign unit_stall = q_full;
    assign push       = unit_valid && !q_full;

    always_comb
    begin
        push_data.code_unit     = c;
        push_data.is_digit      = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        push_data.digit         = c_off[3:0];
        push_data.is_plus       = (c == CHAR_PLUS);
        push_data.is_minus      = (c == CHAR_MINUS);
        push_data.is_last       = unit_data.is_last;
        push_data.no_text       = unit_data.no_text;
        push_data.fallback_seed = unit_data.fallback_seed;
    end

endmodule

FILE: sv/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// short fifo of classified units between front and back
// ----------------------------------------------------------------------------
module stt_queue #(
    parameter int DEPTH = stt_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  stt_pkg::unit_t push_data,
    input  logic           pop,
    output logic           full,
    output logic           q_valid,
    output stt_pkg::unit_t q_data
);
    import stt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    unit_t              slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// runs the decimal parse and text hash, one unit per cycle while a unit is
// queued and no closing unit waits on a stalled output, and registers the seed
// ----------------------------------------------------------------------------
module stt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  stt_pkg::unit_t q_data,
    output logic           pop,
    output logic           seed_valid,
    input  logic           seed_stall,
    output stt_pkg::out_t  seed_data
);
    import stt_pkg::*;

    // magnitude and its negative kept side by side, so no negate at the end
    logic [63:0] mag_reg, mag_next;
    logic [63:0] nacc_reg, nacc_next;
    logic        neg_reg, neg_next;
    logic        started_reg, started_next;
    logic        digit_reg, digit_next;
    logic        failed_reg, failed_next;
    logic [31:0] hash_reg, hash_next;
    logic        out_valid_reg, out_valid_next;
    out_t        out_reg, out_next;

    // one step of the parse, before any clear
    logic [63:0] s_mag, s_nacc;
    logic        s_neg, s_digit, s_failed;
    logic [31:0] s_hash;
    logic [63:0] dig64;
    logic [3:0]  last_digit;
    logic        over;
    logic        ends;
    logic        out_free;

    assign dig64      = {60'b0, q_data.digit};
    assign last_digit = neg_reg ? LAST_DIGIT_NEG : LAST_DIGIT_POS;
    assign over       = (mag_reg > MAG_STEP_LIMIT)
                     || ((mag_reg == MAG_STEP_LIMIT) && (q_data.digit > last_digit));
    assign ends       = q_data.no_text || q_data.is_last;
    assign out_free   = !out_valid_reg || !seed_stall;
    assign pop        = q_valid && (!ends || out_free);

    always_comb
    begin
        s_mag    = mag_reg;
        s_nacc   = nacc_reg;
        s_neg    = neg_reg;
        s_digit  = digit_reg;
        s_failed = failed_reg;
        s_hash   = hash_reg * HASH_MULT + {16'b0, q_data.code_unit};
        if (!failed_reg)
        begin
            priority if (!started_reg && (q_data.is_plus || q_data.is_minus))
            begin
                s_neg = q_data.is_minus;
            end
            else if (!q_data.is_digit || over)
            begin
                s_failed = 1'b1;
            end
            else
            begin
                s_mag   = (mag_reg << 3) + (mag_reg << 1) + dig64;
                s_nacc  = (nacc_reg << 3) + (nacc_reg << 1) - dig64;
                s_digit = 1'b1;
            end
        end
    end

    always_comb
    begin
        mag_next       = mag_reg;
        nacc_next      = nacc_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        digit_next     = digit_reg;
        failed_next    = failed_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && seed_stall;
        out_next       = out_reg;
        if (pop)
        begin
            if (ends)
            begin
                out_valid_next = 1'b1;
                priority if (q_data.no_text)
                begin
                    out_next.seed   = q_data.fallback_seed;
                    out_next.source = SRC_FALLBACK;
                end
                else if (s_failed || !s_digit)
                begin
                    out_next.seed   = {{32{s_hash[31]}}, s_hash};
                    out_next.source = SRC_HASH;
                end
                else if (s_mag == '0)
                begin
                    out_next.seed   = q_data.fallback_seed;
                    out_next.source = SRC_FALLBACK;
                end
                else
                begin
                    out_next.seed   = s_neg ? s_nacc : s_mag;
                    out_next.source = SRC_PARSED;
                end
                mag_next     = '0;
                nacc_next    = '0;
                neg_next     = 1'b0;
                started_next = 1'b0;
                digit_next   = 1'b0;
                failed_next  = 1'b0;
                hash_next    = '0;
            end
            else
            begin
                mag_next     = s_mag;
                nacc_next    = s_nacc;
                neg_next     = s_neg;
                started_next = 1'b1;
                digit_next   = s_digit;
                failed_next  = s_failed;
                hash_next    = s_hash;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg       <= '0;
            nacc_reg      <= '0;
            neg_reg       <= 1'b0;
            started_reg   <= 1'b0;
            digit_reg     <= 1'b0;
            failed_reg    <= 1'b0;
            hash_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mag_reg       <= mag_next;
            nacc_reg      <= nacc_next;
            neg_reg       <= neg_next;
            started_reg   <= started_next;
            digit_reg     <= digit_next;
            failed_reg    <= failed_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign seed_valid = out_valid_reg;
    assign seed_data  = out_reg;

endmodule

FILE: sv/seed_text_to_long_top.sv
// ----------------------------------------------------------------------------
// seed_text_to_long_top
// decimal seed text to signed 64-bit seed, with hash and fallback
// ----------------------------------------------------------------------------
// Takes one UTF-16 code unit per request and, on the last unit (or an empty
// text request), returns one 64-bit seed: the parsed decimal value, the
// sign-extended 31x text hash when the text is not a valid integer, or the
// supplied fallback seed for an empty text or a parse of zero. A new request
// is taken every cycle while the queue has room. With an empty queue and a
// free output, the closing request passes through a queue slot and then the
// back end's output register before seed_valid rises. The rate is set by the
// back end's per-unit step, a multiply by ten with add and limit compare on
// the 64-bit magnitude. A small queue between the classifier and the back
// end absorbs output stalls; requests are stalled only when it is full.
module seed_text_to_long_top #(
    parameter int QUEUE_DEPTH = stt_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          unit_valid,
    output logic          unit_stall,
    input  stt_pkg::in_t  unit_data,
    output logic          seed_valid,
    input  logic          seed_stall,
    output stt_pkg::out_t seed_data
);
    import stt_pkg::*;

`include "assert_macros.svh"

    logic  push;
    unit_t push_data;
    logic  q_full;
    logic  q_valid;
    unit_t q_data;
    logic  pop;

    stt_front u_front (
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_data  (unit_data),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    stt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    stt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .pop        (pop),
        .seed_valid (seed_valid),
        .seed_stall (seed_stall),
        .seed_data  (seed_data)
    );

    // back end never reads an empty queue
    `ASSERT_IMPLIES(a_pop_has_data, pop, q_valid, "pop from empty queue")
    // a parsed seed of zero must have gone to the fallback
    `ASSERT_IMPLIES(a_parsed_nonzero, seed_valid && seed_data.source == SRC_PARSED,
        seed_data.seed != '0, "parsed seed is zero")
    // hash seeds are sign-extended 32-bit values
    `ASSERT_IMPLIES(a_hash_sext, seed_valid && seed_data.source == SRC_HASH,
        seed_data.seed[63:32] == {32{seed_data.seed[31]}}, "hash seed not sign-extended")

endmodule
